### design/hslp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP status line parser package
// Shared types and constants for the status line parser and its top level.
// ----------------------------------------------------------------------------
package hslp_pkg;

    // Parse states, one-hot.
    typedef enum logic [10:0] {
        ST_H1     = 11'b000_0000_0001,
        ST_T1     = 11'b000_0000_0010,
        ST_T2     = 11'b000_0000_0100,
        ST_P      = 11'b000_0000_1000,
        ST_SLASH  = 11'b000_0001_0000,
        ST_MAJOR  = 11'b000_0010_0000,
        ST_MINOR  = 11'b000_0100_0000,
        ST_SKIP   = 11'b000_1000_0000,
        ST_STATUS = 11'b001_0000_0000,
        ST_EOL    = 11'b010_0000_0000,
        ST_ERROR  = 11'b100_0000_0000
    } parse_state_t;

    typedef enum logic [1:0] {
        OUT_OK    = 2'd0,
        OUT_BAD   = 2'd1,
        OUT_ABORT = 2'd2
    } outcome_t;

    typedef struct packed {
        outcome_t    outcome;
        logic [15:0] version_word;
        logic [15:0] status_code;
    } hslp_result_t;

    localparam logic [7:0]  CH_H_UP   = 8'h48;
    localparam logic [7:0]  CH_H_LO   = 8'h68;
    localparam logic [7:0]  CH_T_UP   = 8'h54;
    localparam logic [7:0]  CH_T_LO   = 8'h74;
    localparam logic [7:0]  CH_P_UP   = 8'h50;
    localparam logic [7:0]  CH_P_LO   = 8'h70;
    localparam logic [7:0]  CH_SLASH  = 8'h2F;
    localparam logic [7:0]  CH_DOT    = 8'h2E;
    localparam logic [7:0]  CH_LF     = 8'h0A;
    localparam logic [7:0]  CH_SPACE  = 8'h20;
    localparam logic [7:0]  CH_TAB    = 8'h09;
    localparam logic [7:0]  CH_ZERO   = 8'h30;
    localparam logic [7:0]  CH_NINE   = 8'h39;

    localparam logic [15:0] VERSION_RESET = 16'h0009;
    localparam logic [15:0] LIMIT_RESET   = 16'd8192;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

endpackage

### design/hslp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP status line parser core
// Holds the parse state and accumulators and works through one byte per
// accepted item, giving at most one result in the same cycle.
// ----------------------------------------------------------------------------
module hslp_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            line_byte,
    input  logic                  link_closed,
    input  logic [15:0]           line_limit,
    output logic                  res_valid,
    output hslp_pkg::hslp_result_t res
);
    import hslp_pkg::*;

    parse_state_t state_reg, state_next;
    logic [15:0]  count_reg, count_next;
    logic [7:0]   major_reg, major_next;
    logic [7:0]   minor_reg, minor_next;
    logic [15:0]  version_reg, version_next;
    logic [15:0]  status_reg, status_next;

    logic         is_digit;
    logic         is_blank;
    logic [3:0]   digit;
    logic [11:0]  major_sum;
    logic [11:0]  minor_sum;
    logic [19:0]  status_sum;
    logic [7:0]   major_sat;
    logic [7:0]   minor_sat;
    logic [15:0]  status_sat;
    logic [15:0]  limit_eff;
    logic         restart;

    assign is_digit = (line_byte >= CH_ZERO) && (line_byte <= CH_NINE);
    assign is_blank = (line_byte == CH_SPACE) || (line_byte == CH_TAB);
    assign digit    = line_byte[3:0];

    // Times ten as two shifts and an add.
    assign major_sum  = {1'b0, major_reg, 3'b000} + {3'b000, major_reg, 1'b0}
                        + {8'd0, digit};
    assign minor_sum  = {1'b0, minor_reg, 3'b000} + {3'b000, minor_reg, 1'b0}
                        + {8'd0, digit};
    assign status_sum = {1'b0, status_reg, 3'b000} + {3'b000, status_reg, 1'b0}
                        + {16'd0, digit};
    assign major_sat  = (major_sum > 12'd255) ? 8'hFF : major_sum[7:0];
    assign minor_sat  = (minor_sum > 12'd255) ? 8'hFF : minor_sum[7:0];
    assign status_sat = (status_sum > 20'd65535) ? 16'hFFFF : status_sum[15:0];

    // A limit of zero behaves as one.
    assign limit_eff = (line_limit == 16'd0) ? 16'd1 : line_limit;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        major_next   = major_reg;
        minor_next   = minor_reg;
        version_next = version_reg;
        status_next  = status_reg;
        res_valid    = 1'b0;
        res.outcome  = OUT_OK;

        if (step)
        begin
            if (link_closed)
            begin
                res_valid   = 1'b1;
                res.outcome = OUT_ABORT;
            end
            else
            begin
                if (count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + 16'd1;
                end

                unique case (state_reg)
                    ST_H1:
                    begin
                        state_next = (line_byte == CH_H_UP || line_byte == CH_H_LO)
                                     ? ST_T1 : ST_ERROR;
                    end
                    ST_T1:
                    begin
                        state_next = (line_byte == CH_T_UP || line_byte == CH_T_LO)
                                     ? ST_T2 : ST_ERROR;
                    end
                    ST_T2:
                    begin
                        state_next = (line_byte == CH_T_UP || line_byte == CH_T_LO)
                                     ? ST_P : ST_ERROR;
                    end
                    ST_P:
                    begin
                        state_next = (line_byte == CH_P_UP || line_byte == CH_P_LO)
                                     ? ST_SLASH : ST_ERROR;
                    end
                    ST_SLASH:
                    begin
                        state_next = (line_byte == CH_SLASH) ? ST_MAJOR : ST_ERROR;
                    end
                    ST_MAJOR:
                    begin
                        if (is_digit)
                        begin
                            major_next = major_sat;
                        end
                        else if (line_byte == CH_DOT)
                        begin
                            state_next = ST_MINOR;
                        end
                        else
                        begin
                            state_next = ST_ERROR;
                        end
                    end
                    ST_MINOR:
                    begin
                        if (is_digit)
                        begin
                            minor_next   = minor_sat;
                            version_next = {major_reg, minor_sat};
                        end
                        else if (is_blank)
                        begin
                            state_next = ST_SKIP;
                        end
                        else
                        begin
                            state_next = ST_ERROR;
                        end
                    end
                    ST_SKIP:
                    begin
                        // A digit here is taken as the first status byte; another non-blank byte is an error.
                        if (is_digit)
                        begin
                            state_next  = ST_STATUS;
                            status_next = status_sat;
                        end
                        else if (!is_blank)
                        begin
                            state_next = ST_ERROR;
                        end
                    end
                    ST_STATUS:
                    begin
                        if (is_digit)
                        begin
                            status_next = status_sat;
                        end
                        else if (is_blank)
                        begin
                            state_next = ST_EOL;
                        end
                        else
                        begin
                            state_next = ST_ERROR;
                        end
                    end
                    ST_EOL:
                    begin
                        if (line_byte == CH_LF)
                        begin
                            res_valid   = 1'b1;
                            res.outcome = OUT_OK;
                        end
                    end
                    default:
                    begin
                        // Error recovery, also entered from any stray state code.
                        state_next = ST_ERROR;
                        if (line_byte == CH_LF)
                        begin
                            res_valid   = 1'b1;
                            res.outcome = OUT_BAD;
                        end
                    end
                endcase

                if (!res_valid && (count_next >= limit_eff))
                begin
                    res_valid   = 1'b1;
                    res.outcome = OUT_BAD;
                end
            end
        end

        res.version_word = version_next;
        res.status_code  = status_next;
    end

    assign restart = res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_H1;
            count_reg   <= 16'd0;
            major_reg   <= 8'd0;
            minor_reg   <= 8'd0;
            version_reg <= VERSION_RESET;
            status_reg  <= 16'd0;
        end
        else if (restart)
        begin
            state_reg   <= ST_H1;
            count_reg   <= 16'd0;
            major_reg   <= 8'd0;
            minor_reg   <= 8'd0;
            version_reg <= VERSION_RESET;
            status_reg  <= 16'd0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            major_reg   <= major_next;
            minor_reg   <= minor_next;
            version_reg <= version_next;
            status_reg  <= status_next;
        end
    end

endmodule

### design/http_status_line_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP status line parser, top level
// Line limit register, parser core and a two-entry result buffer.
// ----------------------------------------------------------------------------
// The block takes one byte item per clock cycle while in_ready is high. A
// result (line accepted, bad request or aborted by link) is registered into
// the output register, or into the skid entry while the output register is
// held. Results go through a two-entry buffer, so bytes keep flowing while
// one result waits to be taken; in_ready drops only when both entries are
// full. The line limit is written through cfg_wr_en/cfg_wr_data and should
// be changed only while the block is idle.
module http_status_line_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  line_byte,
    input  logic        link_closed,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  outcome,
    output logic [15:0] version_word,
    output logic [15:0] status_code
);
    import hslp_pkg::*;

    logic [15:0]  limit_reg;
    logic         accept;
    logic         res_valid;
    hslp_result_t res;
    logic         out_valid_reg;
    hslp_result_t out_reg;
    logic         skid_valid_reg;
    hslp_result_t skid_reg;
    logic         pop;

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;
    assign pop      = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            limit_reg <= cfg_wr_data;
        end
    end

    hslp_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (accept),
        .line_byte   (line_byte),
        .link_closed (link_closed),
        .line_limit  (limit_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Output register with a skid entry behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || pop)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= res_valid;
                end
            end
            else if (res_valid)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        if (res_valid && out_valid_reg && !pop)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign outcome      = out_reg.outcome;
    assign version_word = out_reg.version_word;
    assign status_code  = out_reg.status_code;

endmodule
